[rtl/text_console_writer_core_defines.svh]
// Assertion macros shared by the text console writer modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTH
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(name, prop, msg)
`define TCW_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_COPY,
    S_BLANK,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    SW_NONE,
    SW_INIT,
    SW_FILL,
    SW_COPY,
    SW_BLANK
  } sweep_t;

  typedef struct packed {
    logic   capture;
    logic   exec;
    logic   home;
    logic   rd_issue;
    logic   out_load;
    sweep_t sweep;
    sweep_t ld_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       need_scroll;
    logic       sweep_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/tcw_datapath.sv]
// Datapath of the text console writer: screen memory, cursor and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t      sts,
  input  wire logic [1:0]    in_req_type,
  input  wire logic [7:0]    in_char_code,
  input  wire logic [10:0]   in_cell_index,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  output logic [15:0]        cell_data,
  output logic [4:0]         cursor_row,
  output logic [6:0]         cursor_col,
  output logic               scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;

  logic [1:0]    req_r;
  logic [7:0]    ch_r;
  logic [10:0]   idx_r;
  logic [7:0]    attr_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic          scr_r, scr_nxt;

  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          cpy_vld_r;
  logic [AW-1:0] cpy_dst_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic          is_nl;
  logic          wrap;
  logic          last_row;
  logic          in_rng;
  logic          step;
  logic [AW-1:0] ptr_start;

  assign is_nl    = (ch_r == tcw_pkg::NEWLINE_CODE);
  assign wrap     = is_nl || (col_r == CW'(COLUMNS - 1));
  assign last_row = (row_r == RW'(ROWS - 1));
  assign in_rng   = (32'(idx_r) < 32'(CELLS));

  assign sts.req         = req_r;
  assign sts.need_scroll = (req_r == tcw_pkg::REQ_PUT) && wrap && last_row;
  assign sts.sweep_last  = (ptr_r == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      ch_r  <= in_char_code;
      idx_r <= in_cell_index;
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    scr_nxt  = scr_r;
    if (cmd.capture) begin
      scr_nxt = 1'b0;
    end
    if (cmd.home) begin
      row_nxt  = '0;
      col_nxt  = '0;
      base_nxt = '0;
    end
    if (cmd.exec) begin
      if (wrap) begin
        col_nxt = '0;
        if (last_row) begin
          scr_nxt = 1'b1;
        end else begin
          row_nxt  = row_r + RW'(1);
          base_nxt = base_r + AW'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
      scr_r  <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
      scr_r  <= scr_nxt;
    end
  end

  always_comb begin
    case (cmd.ld_op)
      tcw_pkg::SW_COPY:  ptr_start = AW'(COLUMNS);
      tcw_pkg::SW_BLANK: ptr_start = AW'(CELLS - COLUMNS);
      default:           ptr_start = '0;
    endcase
  end

  always_comb begin
    step = 1'b0;
    case (cmd.sweep)
      tcw_pkg::SW_INIT,
      tcw_pkg::SW_FILL,
      tcw_pkg::SW_COPY:  step = 1'b1;
      tcw_pkg::SW_BLANK: step = !cpy_vld_r;
      default:           step = 1'b0;
    endcase
    if (cmd.ld_op != tcw_pkg::SW_NONE) begin
      ptr_nxt = ptr_start;
    end else if (step && !sts.sweep_last) begin
      ptr_nxt = ptr_r + AW'(1);
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      cpy_vld_r <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      cpy_vld_r <= (cmd.sweep == tcw_pkg::SW_COPY);
    end
  end

  always_ff @(posedge clk) begin
    cpy_dst_r <= ptr_r - AW'(COLUMNS);
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = {attr_r, tcw_pkg::SPACE_CODE};
    if (cmd.exec && !is_nl) begin
      we    = 1'b1;
      waddr = base_r + AW'(col_r);
      wdata = {attr_r, ch_r};
    end else if (cpy_vld_r) begin
      we    = 1'b1;
      waddr = cpy_dst_r;
      wdata = rdata_r;
    end else begin
      case (cmd.sweep)
        tcw_pkg::SW_INIT: begin
          we    = 1'b1;
          wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
        end
        tcw_pkg::SW_FILL,
        tcw_pkg::SW_BLANK: we = 1'b1;
        default:           we = 1'b0;
      endcase
    end
  end

  assign re    = cmd.rd_issue || (cmd.sweep == tcw_pkg::SW_COPY);
  assign raddr = (cmd.sweep == tcw_pkg::SW_COPY) ? ptr_r : AW'(idx_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_data  <= ((req_r == tcw_pkg::REQ_READ) && in_rng) ? rdata_r : 16'd0;
      cursor_row <= 5'(row_nxt);
      cursor_col <= 7'(col_nxt);
      scrolled   <= scr_nxt;
    end
  end

  `include "text_console_writer_core_defines.svh"

  `TCW_ASSERT(a_cursor_range, (32'(col_r) < 32'(COLUMNS)) && (32'(row_r) < 32'(ROWS)), "cursor out of range")
  `TCW_ASSERT(a_base_tracks_row, 32'(base_r) == 32'(row_r) * 32'(COLUMNS), "row base mismatch")
  `TCW_ASSERT(a_copy_in_scroll, cpy_vld_r |-> (cmd.sweep == tcw_pkg::SW_COPY || cmd.sweep == tcw_pkg::SW_BLANK), "copy write outside scroll")

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
// Controller of the text console writer: sequences requests, sweeps and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t      cmd
);

  tcw_pkg::state_t state_r, state_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            out_free;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcw_pkg::S_INIT;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_vld_nxt = out_vld_r && !out_tready;
    case (state_r)
      tcw_pkg::S_INIT: begin
        cmd.sweep = tcw_pkg::SW_INIT;
        if (sts.sweep_last) begin
          state_nxt = tcw_pkg::S_IDLE;
        end
      end
      tcw_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = tcw_pkg::S_EXEC;
        end
      end
      tcw_pkg::S_EXEC: begin
        case (sts.req)
          tcw_pkg::REQ_CLEAR: begin
            cmd.home  = 1'b1;
            cmd.ld_op = tcw_pkg::SW_FILL;
            state_nxt = tcw_pkg::S_CLEAR;
          end
          tcw_pkg::REQ_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = tcw_pkg::S_DONE;
          end
          default: begin
            cmd.exec = (sts.req == tcw_pkg::REQ_PUT);
            if (sts.need_scroll) begin
              cmd.ld_op = tcw_pkg::SW_COPY;
              state_nxt = tcw_pkg::S_COPY;
            end else if (out_free) begin
              cmd.out_load = 1'b1;
              out_vld_nxt  = 1'b1;
              state_nxt    = tcw_pkg::S_IDLE;
            end else begin
              state_nxt = tcw_pkg::S_DONE;
            end
          end
        endcase
      end
      tcw_pkg::S_CLEAR: begin
        cmd.sweep = tcw_pkg::SW_FILL;
        if (sts.sweep_last) begin
          state_nxt = tcw_pkg::S_DONE;
        end
      end
      tcw_pkg::S_COPY: begin
        cmd.sweep = tcw_pkg::SW_COPY;
        if (sts.sweep_last) begin
          cmd.ld_op = tcw_pkg::SW_BLANK;
          state_nxt = tcw_pkg::S_BLANK;
        end
      end
      tcw_pkg::S_BLANK: begin
        cmd.sweep = tcw_pkg::SW_BLANK;
        if (sts.sweep_last) begin
          state_nxt = tcw_pkg::S_DONE;
        end
      end
      tcw_pkg::S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase
  end

  `include "text_console_writer_core_defines.svh"

  `TCW_ASSERT(a_load_into_free_slot, cmd.out_load |-> (!out_vld_r || out_tready), "result overwritten")
  `TCW_ASSERT(a_one_item_at_a_time, (in_tvalid && in_tready) |=> !in_tready, "second item taken early")
  `TCW_ASSERT(a_result_after_load, cmd.out_load |=> out_tvalid, "loaded result not shown")

endmodule

`default_nettype wire

[rtl/text_console_writer_core.sv]
// Top level of the text console writer: 80x25 text screen store with cursor.
//
//  Channel | Dir | Handshake                | Payload
//  in_     | in  | in_tvalid / in_tready    | tuser: req_type; tdata: char_code, cell_index
//  out_    | out | out_tvalid / out_tready  | tdata: cell_data, cursor_row, cursor_col, scrolled
//  cfg_    | in  | cfg_wr_en                | cfg_wr_data: text_attribute
//
// A clear homes the cursor and writes blanks in the current attribute to every cell in turn
// through the single memory write port. A put that scrolls moves each row up: one cell copied
// per cycle, then the bottom row blanked.
// After reset the screen memory is filled with blanks while no item is taken.
// One item is in work at a time; a finished result waits in the output register without
// blocking the next item's acceptance.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code, cell_index, zero fill
  input  wire logic [1:0]  in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // cell_data, cursor_row, cursor_col, scrolled, zero fill
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;
  logic [15:0]   cell_data;
  logic [4:0]    cursor_row;
  logic [6:0]    cursor_col;
  logic          scrolled;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_tuser),
    .in_char_code  (in_tdata[7:0]),
    .in_cell_index (in_tdata[18:8]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cell_data     (cell_data),
    .cursor_row    (cursor_row),
    .cursor_col    (cursor_col),
    .scrolled      (scrolled)
  );

  assign out_tdata = {3'b000, scrolled, cursor_col, cursor_row, cell_data};

endmodule

`default_nettype wire

[bench/text_console_writer_core_test.sv]
// Self-checking testbench of the text console writer core, with its own screen predictor.
`timescale 1ns / 1ps

module text_console_writer_core_test;

  localparam int SCREEN_COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int SCREEN_ROWS  = tcw_pkg::ROWS_DEF;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } console_status_t;

  typedef struct packed {
    logic [1:0]      req;
    logic [7:0]      ch;
    logic [10:0]     idx;
    logic            typed;
    console_status_t status;
  } directed_row_t;

  localparam console_status_t HOME_EMPTY = '0;
  localparam console_status_t HOME_BLANK = '{
    cell_word: {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE}, row: 5'd0,
    col: 7'd0, scrolled: 1'b0};
  localparam int DIRECTED_COUNT = 23;

  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd0,    1'b1, HOME_BLANK},
    '{tcw_pkg::REQ_READ,  8'hFF,                 11'd1999, 1'b1, HOME_BLANK},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd2000, 1'b1, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd2047, 1'b1, HOME_EMPTY},
    '{REQ_UNUSED,         8'hFF,                 11'd2047, 1'b1, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   8'h41,                 11'd0,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   8'h00,                 11'd2047, 1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   8'hFF,                 11'd1365, 1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd0,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd1,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd2,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd3,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   tcw_pkg::NEWLINE_CODE, 11'd682,  1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   8'h55,                 11'd0,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   8'hAA,                 11'd0,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd80,   1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd81,   1'b0, HOME_EMPTY},
    '{REQ_UNUSED,         tcw_pkg::NEWLINE_CODE, 11'd80,   1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_PUT,   tcw_pkg::NEWLINE_CODE, 11'd0,    1'b0, HOME_EMPTY},
    '{tcw_pkg::REQ_CLEAR, 8'hFF,                 11'd2047, 1'b1, HOME_EMPTY},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd0,    1'b1, HOME_BLANK},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd80,   1'b1, HOME_BLANK},
    '{tcw_pkg::REQ_READ,  8'h00,                 11'd1999, 1'b1, HOME_BLANK}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // char_code, cell_index, zero fill
  logic [1:0]  in_tuser = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // cell_data, cursor_row, cursor_col, scrolled, zero fill
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  logic [15:0] screen_model [SCREEN_CELLS];
  int          cursor_row;
  int          cursor_col;
  logic [7:0]  text_attr;

  console_status_t status_queue [$];
  console_status_t got_status;
  console_status_t want_status;
  int          failures = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  text_console_writer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit next_line();
    cursor_col = 0;
    cursor_row++;
    if (cursor_row < SCREEN_ROWS) return 1'b0;
    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
      screen_model[i] = screen_model[i + SCREEN_COLS];
    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
      screen_model[i] = {text_attr, tcw_pkg::SPACE_CODE};
    cursor_row = SCREEN_ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_status_t apply_request(logic [1:0] req, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_status_t s;
    s = '0;
    case (req)
      tcw_pkg::REQ_PUT: begin
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          s.scrolled = next_line();
        end else begin
          screen_model[cursor_row * SCREEN_COLS + cursor_col] = {text_attr, ch};
          cursor_col++;
          if (cursor_col >= SCREEN_COLS) s.scrolled = next_line();
        end
      end
      tcw_pkg::REQ_CLEAR: begin
        for (int i = 0; i < SCREEN_CELLS; i++)
          screen_model[i] = {text_attr, tcw_pkg::SPACE_CODE};
        cursor_row = 0;
        cursor_col = 0;
      end
      tcw_pkg::REQ_READ: begin
        if (int'(idx) < SCREEN_CELLS) s.cell_word = screen_model[idx];
      end
      default: begin
      end
    endcase
    s.row = cursor_row[4:0];
    s.col = cursor_col[6:0];
    return s;
  endfunction

  // Mostly cells near the cursor, where recent writes and scrolls show up.
  function automatic logic [10:0] pick_cell_index();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 11'(cursor_row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
    if (pick < 55 && cursor_row > 0)
      return 11'((cursor_row - 1) * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
    if (pick < 65) return 11'($urandom_range(SCREEN_CELLS - SCREEN_COLS, SCREEN_CELLS - 1));
    if (pick < 75) return 11'($urandom_range(SCREEN_CELLS, 2047));
    return 11'($urandom_range(0, 2047));
  endfunction

  task automatic send_request(logic [1:0] req, logic [7:0] ch, logic [10:0] idx,
                              bit typed = 1'b0, console_status_t typed_status = '0);
    console_status_t s;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'b0, idx, ch};
    do @(posedge clk); while (!in_tready);
    s = apply_request(req, ch, idx);
    status_queue.push_back(typed ? typed_status : s);
    items_sent++;
  endtask

  task automatic send_put(logic [7:0] ch);
    send_request(tcw_pkg::REQ_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic send_read();
    send_request(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)), pick_cell_index());
  endtask

  task automatic write_attribute(logic [7:0] value);
    while (status_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_attr = value;
  endtask

  // Text lines ending in newlines dominate, so the cursor wraps and the screen scrolls often.
  task automatic run_random(int count);
    int target;
    int kind;
    int len;
    logic [7:0] ch;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(79, 80);
          1, 2:    len = $urandom_range(70, 90);
          default: len = $urandom_range(0, 10);
        endcase
        for (int i = 0; i < len; i++) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == tcw_pkg::NEWLINE_CODE) ch = tcw_pkg::SPACE_CODE;
          send_put(ch);
          if ($urandom_range(0, 99) < 20) send_read();
        end
        if ($urandom_range(0, 9) != 0) send_put(tcw_pkg::NEWLINE_CODE);
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 8)) send_put(tcw_pkg::NEWLINE_CODE);
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 6)) send_read();
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: send_put(8'($urandom_range(0, 255)));
            1: send_request(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, 2047)));
            default: send_request(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                  11'($urandom_range(0, 2047)));
          endcase
        end
      end else begin
        send_request(tcw_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, 2047)));
      end
    end
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_status = '{cell_word: out_tdata[15:0], row: out_tdata[20:16], col: out_tdata[27:21],
                     scrolled: out_tdata[28]};
      if (status_queue.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) $display("Unexpected result: tdata %h", out_tdata);
      end else begin
        want_status = status_queue.pop_front();
        if (got_status != want_status) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("Mismatch: cell %h/%h row %0d/%0d col %0d/%0d scrolled %0d/%0d",
                     want_status.cell_word, got_status.cell_word, want_status.row,
                     got_status.row, want_status.col, got_status.col, want_status.scrolled,
                     got_status.scrolled);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SCREEN_CELLS; i++)
      screen_model[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
    cursor_row = 0;
    cursor_col = 0;
    text_attr  = tcw_pkg::RESET_ATTR;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 25;
    recv_idle = 56;
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_request(directed_rows[i].req, directed_rows[i].ch, directed_rows[i].idx,
                   directed_rows[i].typed, directed_rows[i].status);
    in_tvalid <= 1'b0;

    write_attribute(8'h00);
    run_random(400);

    send_idle = 56;
    recv_idle = 25;
    write_attribute(8'hFF);
    run_random(400);

    send_idle = 0;
    recv_idle = 0;
    write_attribute(8'($urandom_range(1, 254)));
    run_random(350);

    while (status_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0 && status_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
